[rtl/moving_average_cross_detector_core_macros.svh]
`ifndef MOVING_AVERAGE_CROSS_DETECTOR_CORE_MACROS_SVH
`define MOVING_AVERAGE_CROSS_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MACD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define MACD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/macd_pkg.sv]
package macd_pkg;

   localparam int MAX_WINDOW_DEF = 64;
   localparam int PRICE_BITS_DEF = 32;

   localparam int PORT_PRICE_BITS = 32;
   localparam int SHORT_BITS      = 6;
   localparam int LONG_BITS       = 7;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 7;
   localparam int SIGNAL_BITS     = 2;

   localparam logic [SHORT_BITS-1:0] SHORT_RESET = 6'd5;
   localparam logic [LONG_BITS-1:0]  LONG_RESET  = 7'd20;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SHORT_WINDOW = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LONG_WINDOW  = 1'b1;

   typedef logic [1:0] relation_type;
   localparam relation_type REL_EQUAL = 2'd0;
   localparam relation_type REL_ABOVE = 2'd1;
   localparam relation_type REL_BELOW = 2'd2;

   typedef logic [SIGNAL_BITS-1:0] signal_type;
   localparam signal_type SIG_INSUFFICIENT = 2'd0;
   localparam signal_type SIG_BUY          = 2'd1;
   localparam signal_type SIG_SELL         = 2'd2;
   localparam signal_type SIG_HOLD         = 2'd3;

endpackage

[rtl/moving_average_cross_detector_core.sv]
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  req_close_price, req_restart
// rsp       out  rsp_valid/rsp_stall  rsp_signal
// csr       in   csr_valid/csr_ready  csr_index, csr_data
//
// One beat per cycle unless req_stall is high; the result is registered at accept.
// Sums, ring write and relation update in the accept cycle; two ring read ports are
// addressed ahead from wp_in with a write-through bypass, so there is no per-item stall.
// reset is synchronous; no clearing pass, ring entries are used only after being written.
// req_stall is high only while a held result is stalled; csr_ready is always high.
// A csr write clears the history.
module moving_average_cross_detector_core #(
   parameter int MAX_WINDOW = macd_pkg::MAX_WINDOW_DEF,
   parameter int PRICE_BITS = macd_pkg::PRICE_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [macd_pkg::PORT_PRICE_BITS-1:0]    req_close_price,
   input  logic                                    req_restart,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [macd_pkg::SIGNAL_BITS-1:0]        rsp_signal,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [macd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [macd_pkg::CSR_DATA_BITS-1:0]      csr_data
);

`include "moving_average_cross_detector_core_macros.svh"

   localparam int AW     = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int IW     = WIN_W + 1;
   localparam int CNT_W  = $clog2(MAX_WINDOW + 3);
   localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW);
   localparam int PROD_W = SUM_W + WIN_W;

   function automatic logic [WIN_W-1:0] eff_long(input logic [macd_pkg::LONG_BITS-1:0] raw);
      logic [WIN_W-1:0] v;
      if (int'(raw) < 2) v = WIN_W'(2);
      else if (int'(raw) > MAX_WINDOW) v = WIN_W'(MAX_WINDOW);
      else v = WIN_W'(raw);
      return v;
   endfunction

   function automatic logic [WIN_W-1:0] eff_short(input logic [macd_pkg::SHORT_BITS-1:0] raw,
                                                  input logic [WIN_W-1:0] l);
      logic [WIN_W-1:0] v;
      if (raw == '0) v = WIN_W'(1);
      else if (int'(raw) > int'(l) - 1) v = l - WIN_W'(1);
      else v = WIN_W'(raw);
      return v;
   endfunction

   function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p, input logic [WIN_W-1:0] w);
      logic [IW-1:0] d;
      d = IW'(p) + IW'(MAX_WINDOW) - IW'(w);
      if (d >= IW'(MAX_WINDOW)) d = d - IW'(MAX_WINDOW);
      return d[AW-1:0];
   endfunction

   logic [macd_pkg::SHORT_BITS-1:0] short_ff, short_in;
   logic [macd_pkg::LONG_BITS-1:0]  long_ff, long_in;
   logic [SUM_W-1:0]                short_sum_ff, short_sum_in;
   logic [SUM_W-1:0]                long_sum_ff, long_sum_in;
   logic [AW-1:0]                   wp_ff, wp_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   macd_pkg::relation_type          rel_ff, rel_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   macd_pkg::signal_type            rsp_signal_ff, rsp_signal_in;

   logic [PRICE_BITS-1:0] price_ring_ff [MAX_WINDOW];
   logic [PRICE_BITS-1:0] rd_short_ff, rd_long_ff;

   logic                  req_accept, csr_write;
   logic [WIN_W-1:0]      len_l, len_s, len_l_in, len_s_in;
   logic [PRICE_BITS-1:0] price;
   logic [CNT_W-1:0]      count0, count1;
   logic [SUM_W-1:0]      ss0, ls0, ss1, ls1;
   logic [AW-1:0]         wa, ra_short, ra_long;
   logic [PROD_W-1:0]     prod_a, prod_b;
   macd_pkg::relation_type rel_prev, rel_now;
   macd_pkg::signal_type   sig;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_signal = rsp_signal_ff;

   assign len_l = eff_long(long_ff);
   assign len_s = eff_short(short_ff, len_l);
   assign price = PRICE_BITS'(req_close_price);

   always_comb begin
      count0 = req_restart ? '0 : count_ff;
      ss0    = req_restart ? '0 : short_sum_ff;
      ls0    = req_restart ? '0 : long_sum_ff;
      rel_prev = req_restart ? macd_pkg::REL_EQUAL : rel_ff;
      wa     = req_restart ? '0 : wp_ff;
      ss1 = ss0 + SUM_W'(price)
            - ((count0 >= CNT_W'(len_s)) ? SUM_W'(rd_short_ff) : SUM_W'(0));
      ls1 = ls0 + SUM_W'(price)
            - ((count0 >= CNT_W'(len_l)) ? SUM_W'(rd_long_ff) : SUM_W'(0));
      count1 = (count0 < CNT_W'(MAX_WINDOW + 2)) ? count0 + CNT_W'(1) : count0;
   end

   assign prod_a = PROD_W'(ss1) * PROD_W'(len_l);
   assign prod_b = PROD_W'(ls1) * PROD_W'(len_s);

   always_comb begin
      rel_now = macd_pkg::REL_EQUAL;
      if (count1 >= CNT_W'(len_l)) begin
         if (prod_a > prod_b) rel_now = macd_pkg::REL_ABOVE;
         else if (prod_a < prod_b) rel_now = macd_pkg::REL_BELOW;
      end
      if (count1 < CNT_W'(len_l) + CNT_W'(2)) sig = macd_pkg::SIG_INSUFFICIENT;
      else if (rel_now == macd_pkg::REL_ABOVE && rel_prev != macd_pkg::REL_ABOVE)
         sig = macd_pkg::SIG_BUY;
      else if (rel_now == macd_pkg::REL_BELOW && rel_prev != macd_pkg::REL_BELOW)
         sig = macd_pkg::SIG_SELL;
      else sig = macd_pkg::SIG_HOLD;
   end

   always_comb begin
      short_in      = short_ff;
      long_in       = long_ff;
      short_sum_in  = short_sum_ff;
      long_sum_in   = long_sum_ff;
      wp_in         = wp_ff;
      count_in      = count_ff;
      rel_in        = rel_ff;
      rsp_signal_in = rsp_signal_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      if (req_accept) begin
         short_sum_in  = ss1;
         long_sum_in   = ls1;
         wp_in         = (wa == AW'(MAX_WINDOW - 1)) ? '0 : wa + AW'(1);
         count_in      = count1;
         rel_in        = rel_now;
         rsp_signal_in = sig;
         rsp_valid_in  = 1'b1;
      end
      if (csr_write) begin
         case (csr_index)
            macd_pkg::REG_SHORT_WINDOW: short_in = csr_data[macd_pkg::SHORT_BITS-1:0];
            macd_pkg::REG_LONG_WINDOW:  long_in  = csr_data[macd_pkg::LONG_BITS-1:0];
            default: ;
         endcase
         short_sum_in = '0;
         long_sum_in  = '0;
         wp_in        = '0;
         count_in     = '0;
         rel_in       = macd_pkg::REL_EQUAL;
      end
      if (reset) begin
         short_in = macd_pkg::SHORT_RESET;
         long_in  = macd_pkg::LONG_RESET;
         wp_in    = '0;
      end
   end

   // read ports look up the entries the next beat will retire
   assign len_l_in = eff_long(long_in);
   assign len_s_in = eff_short(short_in, len_l_in);
   assign ra_short = ring_back(wp_in, len_s_in);
   assign ra_long  = ring_back(wp_in, len_l_in);

   always_ff @(posedge clock) begin
      if (req_accept) price_ring_ff[wa] <= price;
      rd_short_ff <= (req_accept && wa == ra_short) ? price : price_ring_ff[ra_short];
      rd_long_ff  <= (req_accept && wa == ra_long) ? price : price_ring_ff[ra_long];
   end

   always_ff @(posedge clock) begin
      rsp_signal_ff <= rsp_signal_in;
      if (reset) begin
         short_ff     <= macd_pkg::SHORT_RESET;
         long_ff      <= macd_pkg::LONG_RESET;
         short_sum_ff <= '0;
         long_sum_ff  <= '0;
         wp_ff        <= '0;
         count_ff     <= '0;
         rel_ff       <= macd_pkg::REL_EQUAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         short_ff     <= short_in;
         long_ff      <= long_in;
         short_sum_ff <= short_sum_in;
         long_sum_ff  <= long_sum_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         rel_ff       <= rel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MACD_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, rsp_valid_ff, "stall without held result")
   `MACD_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_accept, rsp_valid_ff, "accepted beat gave no result")
   `MACD_ASSERT_NEXT(a_restart_insufficient, clock, reset, req_accept && req_restart, rsp_signal_ff == macd_pkg::SIG_INSUFFICIENT, "restart beat not insufficient")
   `MACD_ASSERT_NEXT(a_csr_clears_history, clock, reset, csr_write, count_ff == '0 && wp_ff == '0, "csr write did not clear history")

endmodule
